// ----- rtl/ili_pkg.sv -----
package ili_pkg;

  // List store size
  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Stream field widths
  localparam int OP_W     = 3;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 6;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int S_DATA_W = ((OP_W + POS_W + VAL_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((VAL_W + STAT_W + COUNT_W + 7) / 8) * 8;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ    = 3'd3;
  localparam logic [OP_W-1:0] OP_REVERSE = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // Command broadcast along the cell row
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_INSERT,
    CMD_DELETE,
    CMD_ROTATE
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e          cmd;
    idx_t               sel;    // push slot, insert/delete index, rotate limit
    logic [VAL_W-1:0]   value;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_REVERSE
  } ctrl_state_e;

endpackage

// ----- rtl/ili_cell.sv -----
module ili_cell (
  input  logic                     clk,
  input  ili_pkg::idx_t            idx,
  input  ili_pkg::cell_ctl_t       ctl,
  input  logic [ili_pkg::VAL_W-1:0] lower,
  input  logic [ili_pkg::VAL_W-1:0] upper,
  input  logic [ili_pkg::VAL_W-1:0] head,
  output logic [ili_pkg::VAL_W-1:0] data
);

  logic [ili_pkg::VAL_W-1:0] data_next;

  // Per-cell choice of source for this cycle
  always_comb begin
    data_next = data;
    unique case (ctl.cmd)
      ili_pkg::CMD_PUSH: begin
        if (idx == ctl.sel) data_next = ctl.value;
      end
      ili_pkg::CMD_INSERT: begin
        if (idx == ctl.sel) data_next = ctl.value;
        else if (idx > ctl.sel) data_next = lower;
      end
      ili_pkg::CMD_DELETE: begin
        if (idx >= ctl.sel) data_next = upper;
      end
      ili_pkg::CMD_ROTATE: begin
        if (idx < ctl.sel) data_next = upper;
        else if (idx == ctl.sel) data_next = head;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ----- rtl/ili_ctrl.sv -----
module ili_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ili_pkg::OP_W-1:0]     op,
  input  logic [ili_pkg::POS_W-1:0]    pos,
  input  logic [ili_pkg::VAL_W-1:0]    value,
  input  logic [ili_pkg::VAL_W-1:0]    rd_word,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ili_pkg::M_DATA_W-1:0] m_tdata,
  output ili_pkg::cell_ctl_t           cell_ctl
);

  localparam int CMP_W = ili_pkg::CMP_W;

  ili_pkg::ctrl_state_e state, state_next;
  ili_pkg::cnt_t        count, count_next;
  ili_pkg::idx_t        limit, limit_next;

  logic                        accept;
  logic [CMP_W-1:0]            pos_x, cnt_x;
  logic                        full;
  logic [ili_pkg::VAL_W-1:0]   rd;
  logic [ili_pkg::STAT_W-1:0]  stat;

  assign s_tready = (state == ili_pkg::S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign pos_x    = CMP_W'(pos);
  assign cnt_x    = CMP_W'(count);
  assign full     = (count == ili_pkg::cnt_t'(ili_pkg::CAPACITY));

  // Decode and sequencing
  always_comb begin
    state_next     = state;
    count_next     = count;
    limit_next     = limit;
    rd             = '0;
    stat           = ili_pkg::STAT_DONE;
    cell_ctl.cmd   = ili_pkg::CMD_HOLD;
    cell_ctl.sel   = ili_pkg::idx_t'(pos);
    cell_ctl.value = value;
    unique case (state)
      ili_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op)
            ili_pkg::OP_PUSH: begin
              if (full) begin
                stat = ili_pkg::STAT_FULL;
              end else begin
                cell_ctl.cmd = ili_pkg::CMD_PUSH;
                cell_ctl.sel = count[ili_pkg::IDX_W-1:0];
                count_next   = count + 1'b1;
              end
            end
            ili_pkg::OP_INSERT: begin
              if (pos_x > cnt_x) begin
                stat = ili_pkg::STAT_RANGE;
              end else if (full) begin
                stat = ili_pkg::STAT_FULL;
              end else begin
                cell_ctl.cmd = ili_pkg::CMD_INSERT;
                count_next   = count + 1'b1;
              end
            end
            ili_pkg::OP_DELETE: begin
              if (pos_x >= cnt_x) begin
                stat = ili_pkg::STAT_RANGE;
              end else begin
                cell_ctl.cmd = ili_pkg::CMD_DELETE;
                count_next   = count - 1'b1;
              end
            end
            ili_pkg::OP_READ: begin
              if (pos_x >= cnt_x) stat = ili_pkg::STAT_RANGE;
              else rd = rd_word;
            end
            ili_pkg::OP_REVERSE: begin
              if (count > ili_pkg::cnt_t'(1)) begin
                state_next = ili_pkg::S_REVERSE;
                limit_next = ili_pkg::idx_t'(count - 1'b1);
              end
            end
            default: ;
          endcase
        end
      end
      ili_pkg::S_REVERSE: begin
        // rotate cells [0..limit] down by one, head lands at limit
        cell_ctl.cmd = ili_pkg::CMD_ROTATE;
        cell_ctl.sel = limit;
        limit_next   = limit - 1'b1;
        if (limit == ili_pkg::idx_t'(1)) state_next = ili_pkg::S_IDLE;
      end
      default: state_next = ili_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ili_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    limit <= limit_next;
  end

  // Result register, freed by a transfer on the master side
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (accept) begin
      m_tdata <= ili_pkg::M_DATA_W'({ili_pkg::COUNT_W'(count_next), stat, rd});
    end
  end

endmodule

// ----- rtl/indexed_list_insert_delete.sv -----
// The result is registered and appears in the cycle after the input transfer; the result register holds it until taken.
// One item per cycle for push, insert, delete and read while the result register is free or being taken;
// reverse blocks input while it rotates the cell row, one cell-row rotation per cycle.
// Reset (rst, synchronous, active high) clears the count, state and result valid;
// cell contents are not reset and are only read below the count.
module indexed_list_insert_delete (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ili_pkg::S_DATA_W-1:0] s_tdata,  // operation, position, value
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ili_pkg::M_DATA_W-1:0] m_tdata   // read_value, status, count
);

  localparam int N    = ili_pkg::CAPACITY;
  localparam int OP_W = ili_pkg::OP_W;
  localparam int PS_W = ili_pkg::POS_W;
  localparam int VL_W = ili_pkg::VAL_W;

  logic [OP_W-1:0]     op;
  logic [PS_W-1:0]     pos;
  logic [VL_W-1:0]     value;
  logic [VL_W-1:0]     cell_data [N];
  logic [VL_W-1:0]     rd_word;
  ili_pkg::cell_ctl_t  cell_ctl;

  // Unpack the input word
  assign op    = s_tdata[OP_W-1:0];
  assign pos   = s_tdata[OP_W+PS_W-1:OP_W];
  assign value = s_tdata[OP_W+PS_W+VL_W-1:OP_W+PS_W];

  // Read port: one selected cell
  assign rd_word = cell_data[ili_pkg::idx_t'(pos)];

  ili_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (op),
    .pos      (pos),
    .value    (value),
    .rd_word  (rd_word),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cell_ctl (cell_ctl)
  );

  // Row of storage cells, each linked to its neighbors and to the head
  for (genvar k = 0; k < N; k++) begin : g_cell
    ili_cell u_cell (
      .clk   (clk),
      .idx   (ili_pkg::idx_t'(k)),
      .ctl   (cell_ctl),
      .lower (cell_data[(k == 0) ? 0 : k - 1]),
      .upper (cell_data[(k == N - 1) ? N - 1 : k + 1]),
      .head  (cell_data[0]),
      .data  (cell_data[k])
    );
  end

endmodule
